/* hdl/fhrc_pkg.sv */
// Shared widths, register index codes, divider beat types and the duty
// conversion for the fan hysteresis ramp control unit.
// No dependencies; every other file in hdl uses it by scoped names.
`default_nettype none

package fhrc_pkg;

	localparam int TEMP_W    = 8;
	localparam int PCT_W     = 7;
	localparam int DUTY_W    = 8;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 8;

	// ramp product: (t - on) up to 254 times |100 - min| up to 100
	localparam int DVD_W     = 15;
	localparam int DSR_W     = 8;
	localparam int DIV_CNT_W = 4;

	localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

	localparam logic signed [TEMP_W-1:0] ON_TEMP_RST  = 8'sd45;
	localparam logic signed [TEMP_W-1:0] OFF_TEMP_RST = 8'sd40;
	localparam logic signed [TEMP_W-1:0] MAX_TEMP_RST = 8'sd70;
	localparam logic [PCT_W-1:0]         MIN_PCT_RST  = 7'd30;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ON_TEMP  = 2'd0,
		REG_OFF_TEMP = 2'd1,
		REG_MAX_TEMP = 2'd2,
		REG_MIN_PCT  = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic             start;
		logic [DVD_W-1:0] dividend;
		logic [DSR_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DVD_W-1:0] quotient;
	} div_rsp_t;

	// p * 255 / 100 truncated, for p in 0..100; the divide by 100 is a
	// multiply by 5243 / 2^19, exact over this range
	function automatic logic [DUTY_W-1:0] duty_of(input logic [PCT_W-1:0] p);
		logic [14:0] x;
		logic [27:0] y;
		x = ({8'd0, p} << 8) - {8'd0, p};
		y = {13'd0, x} * 28'd5243;
		return y[26:19];
	endfunction

endpackage

`default_nettype wire

/* hdl/fhrc_div.sv */
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on fhrc_pkg for widths and the request and response beat types.
`default_nettype none

module fhrc_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire fhrc_pkg::div_req_t req,
	output fhrc_pkg::div_rsp_t     rsp
);

	logic [fhrc_pkg::DVD_W-1:0]     dvd_q;
	logic [fhrc_pkg::DSR_W-1:0]     dsr_q;
	logic [fhrc_pkg::DSR_W-1:0]     rem_q;
	logic [fhrc_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                           busy_q;
	logic                           done_q;

	logic [fhrc_pkg::DSR_W:0] shifted;
	logic [fhrc_pkg::DSR_W:0] trial;
	logic                     fits;

	assign shifted = {rem_q, dvd_q[fhrc_pkg::DVD_W-1]};
	assign trial   = shifted - {1'b0, dsr_q};
	assign fits    = shifted >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == fhrc_pkg::DIV_CNT_W'(fhrc_pkg::DVD_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// datapath: dividend shifts out at the top, quotient bits enter at the bottom
	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dsr_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[fhrc_pkg::DVD_W-2:0], fits};
			rem_q <= fits ? trial[fhrc_pkg::DSR_W-1:0] : shifted[fhrc_pkg::DSR_W-1:0];
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = dvd_q;

endmodule

`default_nettype wire

/* hdl/fan_hysteresis_ramp_control_unit.sv */
// Fan hysteresis ramp control: one temperature beat in, one percent/duty beat out.
// An accepted beat passes decide and output when no ramp division is needed, and decide,
// multiply, the 15-step bit-serial divider and output when the ramp interpolates. Intake
// reopens only after the output state; an output stall holds the unit in that state.
// Reset (async, active low): fan off, thresholds 45/40/70 C, minimum 30 percent.
// Depends on fhrc_pkg and fhrc_div.
`default_nettype none

module fan_hysteresis_ramp_control_unit (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// temperature beats
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic signed [fhrc_pkg::TEMP_W-1:0] temperature,
	// result beats
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic [fhrc_pkg::PCT_W-1:0]              fan_percent,
	output logic [fhrc_pkg::DUTY_W-1:0]             pwm_duty,
	// register writes
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [fhrc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [fhrc_pkg::CFG_DAT_W-1:0]     cfg_data
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_MUL,
		ST_DIV,
		ST_OUT
	} state_t;

	state_t state_q;

	// configuration registers
	logic signed [fhrc_pkg::TEMP_W-1:0] on_q;
	logic signed [fhrc_pkg::TEMP_W-1:0] off_q;
	logic signed [fhrc_pkg::TEMP_W-1:0] max_q;
	logic [fhrc_pkg::PCT_W-1:0]         min_q;

	// fan state and output registers
	logic [fhrc_pkg::PCT_W-1:0]  cur_q;
	logic                        out_valid_q;
	logic [fhrc_pkg::PCT_W-1:0]  fan_percent_q;
	logic [fhrc_pkg::DUTY_W-1:0] pwm_duty_q;

	// per-item working registers
	logic signed [fhrc_pkg::TEMP_W-1:0] t_q;
	logic [fhrc_pkg::DSR_W-1:0]         diff_q;
	logic [fhrc_pkg::DSR_W-1:0]         span_q;
	logic [fhrc_pkg::PCT_W-1:0]         mag_q;
	logic                               neg_q;

	fhrc_pkg::div_req_t div_req;
	fhrc_pkg::div_rsp_t div_rsp;

	// ---------------------------------------------------------------
	// Handshakes. The input side opens only when no item is in flight;
	// the output register decouples a stalled consumer from intake.
	// ---------------------------------------------------------------
	assign in_stall    = (state_q != ST_IDLE);
	assign cfg_ready   = 1'b1;
	assign out_valid   = out_valid_q;
	assign fan_percent = fan_percent_q;
	assign pwm_duty    = pwm_duty_q;

	logic in_beat;
	logic out_free;
	assign in_beat  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// ---------------------------------------------------------------
	// Register writes: indexes beyond the list do not exist on a 2-bit port.
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			on_q  <= fhrc_pkg::ON_TEMP_RST;
			off_q <= fhrc_pkg::OFF_TEMP_RST;
			max_q <= fhrc_pkg::MAX_TEMP_RST;
			min_q <= fhrc_pkg::MIN_PCT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (fhrc_pkg::reg_idx_t'(cfg_index))
				fhrc_pkg::REG_ON_TEMP:  on_q  <= $signed(cfg_data);
				fhrc_pkg::REG_OFF_TEMP: off_q <= $signed(cfg_data);
				fhrc_pkg::REG_MAX_TEMP: max_q <= $signed(cfg_data);
				fhrc_pkg::REG_MIN_PCT:  min_q <= cfg_data[fhrc_pkg::PCT_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Decision terms, all from the latched sample and the registers.
	// ---------------------------------------------------------------
	logic                               t_lt_on;
	logic                               t_le_on;
	logic                               t_le_off;
	logic                               t_ge_max;
	logic signed [fhrc_pkg::TEMP_W:0]   diff_w;
	logic signed [fhrc_pkg::TEMP_W:0]   span_w;
	logic signed [fhrc_pkg::PCT_W:0]    span_p_w;
	logic [fhrc_pkg::PCT_W-1:0]         min_clamped;

	assign t_lt_on  = t_q <  on_q;
	assign t_le_on  = t_q <= on_q;
	assign t_le_off = t_q <= off_q;
	assign t_ge_max = t_q >= max_q;

	// on the ramp path on < t < max, so both spans are positive and fit 8 bits
	assign diff_w   = {t_q[fhrc_pkg::TEMP_W-1], t_q} - {on_q[fhrc_pkg::TEMP_W-1], on_q};
	assign span_w   = {max_q[fhrc_pkg::TEMP_W-1], max_q} - {on_q[fhrc_pkg::TEMP_W-1], on_q};
	// percent span runs from -27 to 100: a minimum above 100 makes the ramp fall
	assign span_p_w = $signed({1'b0, fhrc_pkg::PCT_FULL}) - $signed({1'b0, min_q});

	assign min_clamped = (min_q > fhrc_pkg::PCT_FULL) ? fhrc_pkg::PCT_FULL : min_q;

	// ---------------------------------------------------------------
	// Ramp end: min plus the signed quotient, then clamp to 0..100.
	// The quotient stays below |100 - min|, so its low bits carry it whole.
	// ---------------------------------------------------------------
	logic [fhrc_pkg::PCT_W-1:0]      quo_w;
	logic signed [fhrc_pkg::PCT_W+1:0] sum_w;
	logic [fhrc_pkg::PCT_W-1:0]      ramp_pct;

	assign quo_w = div_rsp.quotient[fhrc_pkg::PCT_W-1:0];
	assign sum_w = neg_q ? ($signed({2'b00, min_q}) - $signed({2'b00, quo_w}))
	                     : ($signed({2'b00, min_q}) + $signed({2'b00, quo_w}));

	always_comb begin
		priority if (sum_w < 0) begin
			ramp_pct = '0;
		end else if (sum_w > $signed({2'b00, fhrc_pkg::PCT_FULL})) begin
			ramp_pct = fhrc_pkg::PCT_FULL;
		end else begin
			ramp_pct = sum_w[fhrc_pkg::PCT_W-1:0];
		end
	end

	// ---------------------------------------------------------------
	// Divider request: the multiply feeds the divider's load register.
	// ---------------------------------------------------------------
	assign div_req.start    = (state_q == ST_MUL);
	assign div_req.dividend = {{(fhrc_pkg::DVD_W-fhrc_pkg::DSR_W){1'b0}}, diff_q}
	                        * {{(fhrc_pkg::DVD_W-fhrc_pkg::PCT_W){1'b0}}, mag_q};
	assign div_req.divisor  = span_q;

	fhrc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// ---------------------------------------------------------------
	// Sequencer: state, fan percent and the output register.
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			cur_q         <= '0;
			out_valid_q   <= 1'b0;
			fan_percent_q <= '0;
			pwm_duty_q    <= '0;
		end else begin
			// drop the result once the consumer takes it, unless a new one replaces it
			if (out_valid_q && !out_stall && state_q != ST_OUT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_beat) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					priority if (cur_q == '0 && t_lt_on) begin
						// stopped fan stays stopped below the on threshold
						state_q <= ST_OUT;
					end else if (cur_q != '0 && t_le_off) begin
						cur_q   <= '0;
						state_q <= ST_OUT;
					end else if (t_le_on) begin
						cur_q   <= min_clamped;
						state_q <= ST_OUT;
					end else if (t_ge_max) begin
						// also covers a max threshold at or below the on threshold
						cur_q   <= fhrc_pkg::PCT_FULL;
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						cur_q   <= ramp_pct;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					// hold until the output register is free
					if (out_free) begin
						out_valid_q   <= 1'b1;
						fan_percent_q <= cur_q;
						pwm_duty_q    <= fhrc_pkg::duty_of(cur_q);
						state_q       <= ST_IDLE;
					end else begin
						out_valid_q   <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// working registers: sample on accept, ramp operands on the way to the divider
	always_ff @(posedge clk) begin
		if (in_beat) begin
			t_q <= temperature;
		end
		if (state_q == ST_DECIDE) begin
			diff_q <= diff_w[fhrc_pkg::DSR_W-1:0];
			span_q <= span_w[fhrc_pkg::DSR_W-1:0];
			neg_q  <= span_p_w[fhrc_pkg::PCT_W];
			mag_q  <= span_p_w[fhrc_pkg::PCT_W]
			          ? fhrc_pkg::PCT_W'(-span_p_w)
			          : span_p_w[fhrc_pkg::PCT_W-1:0];
		end
	end

`ifndef SYNTHESIS
	// the divider only finishes while the sequencer waits for it
	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == ST_DIV)
		else $error("divider finished outside the divide state");

	// an accepted beat closes intake on the next cycle
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat |=> in_stall)
		else $error("second item taken while one is in flight");

	// a fresh result carries the stored fan state, never above full speed
	a_result_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && out_free) |=>
			(out_valid && fan_percent == cur_q && cur_q <= fhrc_pkg::PCT_FULL))
		else $error("result does not match the stored fan percent");
`endif

endmodule

`default_nettype wire

/* verif/fan_hysteresis_ramp_control_unit_tb.sv */
// Self-checking testbench for fan_hysteresis_ramp_control_unit: hysteresis, ramp and
// duty checked beat by beat against an in-bench fan speed predictor.
// Depends on fhrc_pkg (widths, register index codes) and the unit under test.
`default_nettype none

module fan_hysteresis_ramp_control_unit_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import fhrc_pkg::*;

	localparam int N_PHASES       = 12;
	localparam int RAND_PER_PHASE = 120;
	localparam int SETTLE_CYCLES  = 24;	// above the ramp latency
	localparam int MAX_REPORTS    = 10;

	typedef struct packed {
		logic [PCT_W-1:0]  pct;
		logic [DUTY_W-1:0] duty;
	} fan_speed_t;

	// Fan speed predictor plus the queue of speeds still owed by the unit.
	class fan_ramp_scoreboard;
		int on_t;
		int off_t;
		int full_t;
		int min_pct;
		int cur_pct;
		fan_speed_t pending_speeds[$];
		int n_fail;
		int n_speeds;
		int n_writes;
		int n_starts;
		int n_stops;
		int n_interp;

		function new();
			on_t    = 45;
			off_t   = 40;
			full_t  = 70;
			min_pct = 30;
			cur_pct = 0;
		endfunction

		function void write_reg(reg_idx_t idx, logic [CFG_DAT_W-1:0] data);
			case (idx)
				REG_ON_TEMP:  on_t = $signed(data);
				REG_OFF_TEMP: off_t = $signed(data);
				REG_MAX_TEMP: full_t = $signed(data);
				REG_MIN_PCT:  min_pct = data[PCT_W-1:0];
				default: ;
			endcase
			n_writes++;
		endfunction

		// Ramp: minimum at or below the on threshold, full at or above the max
		// threshold, truncating interpolation between them.
		function int ramp_pct(int t);
			if (t <= on_t)
				return min_pct;
			if (t >= full_t)
				return 100;
			n_interp++;
			return min_pct + ((t - on_t) * (100 - min_pct)) / (full_t - on_t);
		endfunction

		function void note_sample(logic signed [TEMP_W-1:0] temp);
			int t;
			int p;
			fan_speed_t s;
			t = temp;
			p = cur_pct;
			if (cur_pct == 0) begin
				if (t >= on_t)
					p = ramp_pct(t);
			end else if (t <= off_t) begin
				p = 0;
			end else begin
				p = ramp_pct(t);
			end
			if (p < 0)
				p = 0;
			if (p > 100)
				p = 100;
			if (cur_pct == 0 && p != 0)
				n_starts++;
			if (cur_pct != 0 && p == 0)
				n_stops++;
			cur_pct = p;
			s.pct = p[PCT_W-1:0];
			s.duty = 8'((p * 255) / 100);
			pending_speeds.push_back(s);
		endfunction

		function void check_speed(logic [PCT_W-1:0] pct, logic [DUTY_W-1:0] duty);
			fan_speed_t s;
			n_speeds++;
			if (pending_speeds.size() == 0) begin
				n_fail++;
				if (n_fail <= MAX_REPORTS)
					$display("[%0t] unexpected result beat: percent %0d duty %0d",
						$realtime, pct, duty);
				return;
			end
			s = pending_speeds.pop_front();
			if (s.pct !== pct || s.duty !== duty) begin
				n_fail++;
				if (n_fail <= MAX_REPORTS)
					$display("[%0t] mismatch: expected percent %0d duty %0d, got %0d / %0d",
						$realtime, s.pct, s.duty, pct, duty);
			end
		endfunction

		function void close_out();
			if (pending_speeds.size() != 0) begin
				n_fail += pending_speeds.size();
				$display("%0d expected result beats never arrived", pending_speeds.size());
			end
		endfunction
	endclass

	// Every input starts at a known value.
	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       in_valid = 1'b0;
	logic                       in_stall;
	logic signed [TEMP_W-1:0]   temperature = '0;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	logic [PCT_W-1:0]           fan_percent;
	logic [DUTY_W-1:0]          pwm_duty;
	logic                       cfg_valid = 1'b0;
	logic                       cfg_ready;
	logic [CFG_IDX_W-1:0]       cfg_index = '0;
	logic [CFG_DAT_W-1:0]       cfg_data = '0;

	fan_ramp_scoreboard fan_sb = new();

	int n_samples = 0;
	int sender_gaps = 0;	// 0: stream back to back, 1: random gaps
	int receiver_stalls = 0;	// 0: never stall, 1: random stalls
	int stall_left = 0;
	int last_temp = 0;

	fan_hysteresis_ramp_control_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.temperature (temperature),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.fan_percent (fan_percent),
		.pwm_duty    (pwm_duty),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always #2 clk = ~clk;

	// Receiver backpressure: mostly short stalls, now and then a long one.
	always @(posedge clk) begin
		int r;
		r = $urandom_range(0, 99);
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else if (receiver_stalls == 0) begin
			out_stall <= 1'b0;
		end else if (r < 25) begin
			out_stall <= 1'b1;
			stall_left = $urandom_range(0, 2);
		end else if (r < 28) begin
			out_stall <= 1'b1;
			stall_left = $urandom_range(10, 40);
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Result monitor: values read here are the ones in effect at this edge.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			fan_sb.check_speed(fan_percent, pwm_duty);
	end

	// Hold until every predicted speed has been seen on the output.
	task automatic wait_idle();
		while (fan_sb.pending_speeds.size() != 0)
			@(posedge clk);
	endtask

	// Write one register; the unit is idle whenever this is called.
	task automatic write_reg(input reg_idx_t idx, input logic [CFG_DAT_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		fan_sb.write_reg(idx, data);
		cfg_valid <= 1'b0;
		repeat ($urandom_range(1, 3)) @(posedge clk);
	endtask

	// Program all four registers; bit 7 of the minimum is noise the unit must drop.
	task automatic configure(input int on_c, input int off_c, input int full_c,
		input int min_c, input logic min_msb);
		write_reg(REG_ON_TEMP, 8'(on_c));
		write_reg(REG_OFF_TEMP, 8'(off_c));
		write_reg(REG_MAX_TEMP, 8'(full_c));
		write_reg(REG_MIN_PCT, {min_msb, 7'(min_c)});
	endtask

	// Send one temperature beat, then idle per the current gap mode. The
	// occasional full pause drops valid and waits out every pending result.
	task automatic send_temp(input logic signed [TEMP_W-1:0] t);
		int r;
		in_valid    <= 1'b1;
		temperature <= t;
		do
			@(posedge clk);
		while (in_stall);
		fan_sb.note_sample(t);
		n_samples++;
		r = $urandom_range(0, 99);
		if (r == 0) begin
			in_valid <= 1'b0;
			wait_idle();
		end else if (sender_gaps != 0 && r >= 60) begin
			in_valid <= 1'b0;
			if (r < 90)
				repeat ($urandom_range(1, 3)) @(posedge clk);
			else if (r < 97)
				repeat ($urandom_range(4, 8)) @(posedge clk);
			else
				repeat ($urandom_range(15, 40)) @(posedge clk);
		end
	endtask

	// Random sample: mostly a slow drift like a real sensor, often right at a
	// threshold, sometimes anywhere in the signed range.
	function automatic logic signed [TEMP_W-1:0] next_temp();
		int r;
		int v;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			v = last_temp + int'($urandom_range(0, 8)) - 4;
		end else if (r < 80) begin
			case ($urandom_range(0, 2))
				0: v = fan_sb.on_t;
				1: v = fan_sb.off_t;
				default: v = fan_sb.full_t;
			endcase
			v = v + int'($urandom_range(0, 4)) - 2;
		end else begin
			v = int'($urandom_range(0, 255)) - 128;
		end
		if (v < -128)
			v = -128;
		if (v > 127)
			v = 127;
		last_temp = v;
		return 8'(v);
	endfunction

	initial begin
		int dir_q[$];
		int off_c;
		int on_c;
		int full_c;

		// Reset once, then release on a clock edge.
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int ph = 0; ph < N_PHASES; ph++) begin
			// Pick the register setting; the early phases aim at the corner cases.
			dir_q = {};
			case (ph)
				0: dir_q = '{0, -128, 44, 45, 46, 69, 70, 127, 41, 40};
				1: begin	// zero minimum: a ramp landing on zero leaves the fan stopped
					configure(20, 10, 60, 0, 1'b0);
					dir_q = '{20, 21, 20};
				end
				2: begin	// minimum above 100: ramp falls and gets clamped
					configure(0, -10, 100, 127, 1'b1);
					dir_q = '{0, 99};
				end
				3: begin	// max threshold below on threshold: no division, full speed
					configure(10, 0, -128, 50, 1'b0);
					dir_q = '{10, 11, 0};
				end
				4: begin	// off threshold above on threshold: start then stop at once
					configure(-20, 127, 0, 100, 1'b1);
					dir_q = '{-20, -19, -128};
				end
				5: begin
					configure(-128, -128, 127, 1, 1'b0);
					dir_q = '{-128, -128, 127};
				end
				6: begin
					configure(127, 127, 127, 100, 1'b1);
					dir_q = '{127, 127};
				end
				default: begin
					if ($urandom_range(0, 9) < 7) begin
						// ordered thresholds with a real ramp between on and max
						off_c  = int'($urandom_range(0, 160)) - 100;
						on_c   = off_c + int'($urandom_range(0, 15));
						full_c = on_c + int'($urandom_range(1, 60));
						if (full_c > 127)
							full_c = 127;
						configure(on_c, off_c, full_c, $urandom_range(0, 100),
							1'($urandom_range(0, 1)));
					end else begin
						configure(int'($urandom_range(0, 255)) - 128,
							int'($urandom_range(0, 255)) - 128,
							int'($urandom_range(0, 255)) - 128,
							$urandom_range(0, 127), 1'($urandom_range(0, 1)));
					end
				end
			endcase

			// New idle pattern per phase; about a third of phases send back to back, a third never stall.
			sender_gaps     = ($urandom_range(0, 2) != 0);
			receiver_stalls = ($urandom_range(0, 2) != 0);

			foreach (dir_q[i])
				send_temp(8'(dir_q[i]));
			repeat (RAND_PER_PHASE) send_temp(next_temp());

			// Drop valid and drain before the next register setting.
			in_valid <= 1'b0;
			wait_idle();
			repeat (SETTLE_CYCLES) @(posedge clk);
		end

		wait_idle();
		repeat (SETTLE_CYCLES) @(posedge clk);
		fan_sb.close_out();
		$display("Sent %0d temperature beats over %0d register settings (%0d register writes).",
			n_samples, N_PHASES, fan_sb.n_writes);
		$display("Fan starts %0d, stops %0d, interpolated ramp points %0d, failures %0d.",
			fan_sb.n_starts, fan_sb.n_stops, fan_sb.n_interp, fan_sb.n_fail);
		if (fan_sb.n_fail == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// Watchdog: a limit several times the slowest correct run.
	initial begin
		#4_000_000;
		$display("Timeout with %0d result beats outstanding.", fan_sb.pending_speeds.size());
		$display("TB_ERROR");
		$finish;
	end

endmodule

`default_nettype wire

/* fan_hysteresis_ramp_control_unit.f */
hdl/fhrc_pkg.sv
hdl/fhrc_div.sv
hdl/fan_hysteresis_ramp_control_unit.sv
verif/fan_hysteresis_ramp_control_unit_tb.sv
